// ===== design/kmmp_pkg.sv =====
package kmmp_pkg;

    // Command queue between parser and result stage
    localparam int CmdDepth = 4;
    localparam int CmdPtrW  = $clog2(CmdDepth);

    // Result kinds
    localparam logic KIND_MOUSE = 1'b0;
    localparam logic KIND_KEY   = 1'b1;

    // Controller message codes
    localparam logic [7:0] CODE_RESET      = 8'h80;
    localparam logic [7:0] CODE_MOUSE      = 8'h00;
    localparam logic [7:0] CODE_BTN_DOWN   = 8'h86;
    localparam logic [7:0] CODE_BTN_UP     = 8'h06;
    localparam logic [3:0] DATE_NIBBLE     = 4'hE;
    localparam logic [2:0] DATE_LEN        = 3'd5;

    // Mouse packet header
    localparam logic [7:0] HDR_BASE        = 8'hF8;
    localparam logic [7:0] HDR_BUTTON      = 8'h02;

    // One parsed transaction handed to the result stage
    typedef struct packed {
        logic       is_key;
        logic       button;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] code;
    } cmd_t;

    localparam logic [7:0] KEY_ROM [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h01, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h4a,
        8'h6a, 8'h6b, 8'h6c, 8'h4e, 8'h71, 8'h6e, 8'h6f, 8'h72,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h0c, 8'h0d, 8'h53, 8'h60, 8'h19, 8'h0e, 8'h00, 8'h00,
        8'h1c, 8'h70, 8'h00, 8'h00, 8'h35, 8'h6d, 8'h00, 8'h00,
        8'h0a, 8'h0b, 8'h16, 8'h17, 8'h24, 8'h25, 8'h1a, 8'h1b,
        8'h32, 8'h26, 8'h27, 8'h28, 8'h39, 8'h33, 8'h34, 8'h18,
        8'h12, 8'h07, 8'h08, 8'h09, 8'h06, 8'h13, 8'h14, 8'h15,
        8'h01, 8'h21, 8'h22, 8'h23, 8'h2f, 8'h2e, 8'h30, 8'h31,
        8'h1e, 8'h03, 8'h04, 8'h05, 8'h02, 8'h10, 8'h1f, 8'h11,
        8'h0f, 8'h2c, 8'h2d, 8'h20, 8'h1d, 8'h3a, 8'h2a, 8'h38
    };

endpackage

// ===== design/kmmp_front.sv =====
module kmmp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  logic [7:0]        controller_byte,
    output logic              cmd_push,
    output kmmp_pkg::cmd_t    cmd_data
);
    import kmmp_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_RESET1 = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_DX     = 3'd3;
    localparam logic [2:0] PH_DY     = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] skip_reg, skip_next;
    logic [7:0] dx_reg, dx_next;
    logic       button_reg, button_next;
    logic       emit;
    cmd_t       cmd;

    // Decode the incoming byte against the current message phase
    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        dx_next     = dx_reg;
        button_next = button_reg;
        emit        = 1'b0;
        cmd.is_key  = KIND_MOUSE;
        cmd.button  = button_reg;
        cmd.dx      = 8'd0;
        cmd.dy      = 8'd0;
        cmd.code    = controller_byte;
        unique case (phase_reg)
            PH_RESET1:
            begin
                if (controller_byte[7:4] == DATE_NIBBLE)
                begin
                    phase_next = PH_SKIP;
                    skip_next  = DATE_LEN;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 3'd1;
                if (skip_next == 3'd0)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DX:
            begin
                dx_next    = controller_byte;
                phase_next = PH_DY;
            end
            PH_DY:
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                cmd.dx     = dx_reg;
                cmd.dy     = controller_byte;
            end
            default:
            begin
                phase_next = PH_IDLE;
                priority if (controller_byte == CODE_RESET)
                begin
                    phase_next = PH_RESET1;
                end
                else if (controller_byte == CODE_MOUSE)
                begin
                    phase_next = PH_DX;
                end
                else if (controller_byte == CODE_BTN_DOWN)
                begin
                    button_next = 1'b1;
                    cmd.button  = 1'b1;
                    emit        = 1'b1;
                end
                else if (controller_byte == CODE_BTN_UP)
                begin
                    button_next = 1'b0;
                    cmd.button  = 1'b0;
                    emit        = 1'b1;
                end
                else
                begin
                    cmd.is_key = KIND_KEY;
                    emit       = 1'b1;
                end
            end
        endcase
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            skip_reg   <= 3'd0;
            dx_reg     <= 8'd0;
            button_reg <= 1'b0;
        end
        else if (in_take)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            dx_reg     <= dx_next;
            button_reg <= button_next;
        end
    end

    assign cmd_push = in_take & emit;
    assign cmd_data = cmd;

endmodule

// ===== design/kmmp_cmd_fifo.sv =====
module kmmp_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  kmmp_pkg::cmd_t    wr_data,
    input  logic              rd_en,
    output kmmp_pkg::cmd_t    rd_data,
    output logic              is_full,
    output logic              is_empty
);
    import kmmp_pkg::*;

    cmd_t               slot_reg [CmdDepth];
    logic [CmdPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CmdPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CmdPtrW:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign is_full  = (count_reg == CmdPtrW'(0) + (CmdPtrW+1)'(CmdDepth));
    assign is_empty = (count_reg == '0);
    assign do_wr    = wr_en & ~is_full;
    assign do_rd    = rd_en & ~is_empty;
    assign rd_data  = slot_reg[rd_ptr_reg];

    // Step pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + CmdPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + CmdPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (CmdPtrW+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (CmdPtrW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/kmmp_back.sv =====
module kmmp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  kmmp_pkg::cmd_t    cmd_data,
    output logic              cmd_take,
    input  logic              pop,
    output logic              empty,
    output logic              event_kind,
    output logic [7:0]        mouse_header,
    output logic signed [7:0] move_x,
    output logic signed [7:0] move_y,
    output logic [7:0]        key_byte
);
    import kmmp_pkg::*;

    logic              valid_reg;
    logic              kind_reg, kind_next;
    logic [7:0]        header_reg, header_next;
    logic signed [7:0] mx_reg, mx_next;
    logic signed [7:0] my_reg, my_next;
    logic [7:0]        key_reg, key_next;
    logic              load;

    // Refill the output register when it is free or being drained
    assign load     = cmd_valid & (~valid_reg | pop);
    assign cmd_take = load;

    // Build the result fields from the queued transaction
    always_comb
    begin
        kind_next   = cmd_data.is_key;
        header_next = 8'd0;
        mx_next     = 8'sd0;
        my_next     = 8'sd0;
        key_next    = 8'd0;
        if (cmd_data.is_key == KIND_KEY)
        begin
            key_next = KEY_ROM[cmd_data.code[6:0]] | {~cmd_data.code[7], 7'd0};
        end
        else
        begin
            header_next = cmd_data.button ? (HDR_BASE | HDR_BUTTON) : HDR_BASE;
            mx_next     = $signed(cmd_data.dx);
            my_next     = $signed(cmd_data.dy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            header_reg <= header_next;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            key_reg    <= key_next;
        end
    end

    assign empty        = ~valid_reg;
    assign event_kind   = kind_reg;
    assign mouse_header = header_reg;
    assign move_x       = mx_reg;
    assign move_y       = my_reg;
    assign key_byte     = key_reg;

endmodule

// ===== design/keyboard_mouse_message_parser_top.sv =====
// Decodes the byte stream of a keyboard/mouse controller into mouse packets
// and translated key bytes. One controller byte is accepted per clock cycle
// while full is low; bytes that only continue a message (reset follow-on,
// skipped date bytes, dx) produce no result, while the dy byte, a button code
// or a key code produces exactly one. A result is written into the four-entry
// command queue when its byte is accepted and moves from there into the output
// register, and is held back in the queue only while the output register still
// holds an older result that the consumer has not taken. Sustained rate is one
// byte per cycle while full is low; full rises only when the queue holds four
// results behind one in the output register that the consumer has not taken.
module keyboard_mouse_message_parser_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        controller_byte,
    output logic              empty,
    input  logic              pop,
    output logic              event_kind,
    output logic [7:0]        mouse_header,
    output logic signed [7:0] move_x,
    output logic signed [7:0] move_y,
    output logic [7:0]        key_byte
);
    import kmmp_pkg::*;

    logic in_take;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic q_full;
    logic q_empty;
    logic cmd_take;

    assign full    = q_full;
    assign in_take = push & ~q_full;

    // Parse incoming bytes
    kmmp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_take         (in_take),
        .controller_byte (controller_byte),
        .cmd_push        (cmd_push),
        .cmd_data        (cmd_in)
    );

    // Decouple parser from result stage
    kmmp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .rd_en    (cmd_take),
        .rd_data  (cmd_out),
        .is_full  (q_full),
        .is_empty (q_empty)
    );

    // Translate and present results
    kmmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (~q_empty),
        .cmd_data     (cmd_out),
        .cmd_take     (cmd_take),
        .pop          (pop),
        .empty        (empty),
        .event_kind   (event_kind),
        .mouse_header (mouse_header),
        .move_x       (move_x),
        .move_y       (move_y),
        .key_byte     (key_byte)
    );

endmodule
